>>> sv/sdrg_pkg.sv
`default_nettype none
package sdrg_pkg;

  // field widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 31;
  localparam int unsigned DIR_W   = 8;
  localparam int unsigned MIDX_W  = 3;
  localparam int unsigned MAX_MOTORS = 8;

  // input word layout, lowest field first
  localparam int unsigned IN_MOTOR_LO  = 0;
  localparam int unsigned IN_FRAC_LO   = IN_MOTOR_LO + MIDX_W;
  localparam int unsigned IN_DIR_LO    = IN_FRAC_LO + WORD_W;
  localparam int unsigned IN_ACCEL_LO  = IN_DIR_LO + DIR_W;
  localparam int unsigned IN_TRAVEL_LO = IN_ACCEL_LO + COUNT_W;
  localparam int unsigned IN_DECEL_LO  = IN_TRAVEL_LO + COUNT_W;
  localparam int unsigned IN_SERIES_LO = IN_DECEL_LO + COUNT_W;
  localparam int unsigned IN_RAMP_LO   = IN_SERIES_LO + WORD_W;
  localparam int unsigned IN_TDLY_LO   = IN_RAMP_LO + WORD_W;
  localparam int unsigned IN_DATA_W    = IN_TDLY_LO + WORD_W;
  localparam int unsigned IN_USER_W    = 3;

  // output word layout
  localparam int unsigned OUT_DATA_W = 2 * DIR_W + WORD_W;
  localparam int unsigned OUT_USER_W = 3;

  // operation codes
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_START   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  // ramp phase codes
  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_TRAVEL = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // accumulator bank control
  typedef struct packed {
    logic                   load;
    logic [MIDX_W-1:0]      motor;
    logic [WORD_W-1:0]      value;
    logic                   clear;
    logic                   advance;
  } acc_ctl_t;

endpackage
`default_nettype wire

>>> sv/stepper_dda_ramp_generator.sv
`default_nettype none
// channel | ports                      | word contents
// --------+----------------------------+-------------------------------------------
// in      | in_tvalid/in_tready        | load fraction, start segment, advance loop
// out     | out_tvalid/out_tready      | one result word per advance
//
// load and start complete in the idle state as they are taken; an advance goes
// through the emit state, and first through the bit-serial divider when the
// ramp delay is updated (accel with n nonzero and every decel loop)
// reset clears all segment state, fractions and accumulators
// a finished result sits in the output register while the next word is taken;
// a stalled output holds the block only when a second result is ready
module stepper_dda_ramp_generator #(
  parameter int unsigned MOTORS              = 8,
  parameter int unsigned DELAY_FRACTION_BITS = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // motor, fraction, dir_mask, accel_loop_count, travel_loop_count,
  // decel_loop_count, series_start, ramp_delay_start, travel_delay
  input  wire logic [sdrg_pkg::IN_DATA_W-1:0]    in_tdata,
  // op, exit_marker
  input  wire logic [sdrg_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // step_pulses, step_directions, loop_delay
  output logic [sdrg_pkg::OUT_DATA_W-1:0]        out_tdata,
  // phase, done_res
  output logic [sdrg_pkg::OUT_USER_W-1:0]        out_tuser
);

  localparam int unsigned W  = sdrg_pkg::WORD_W;
  localparam int unsigned CW = sdrg_pkg::COUNT_W;
  localparam int unsigned DW = sdrg_pkg::DIR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  // input fields
  logic [1:0]                  in_op;
  logic                        in_exit;
  logic [sdrg_pkg::MIDX_W-1:0] in_motor;
  logic [W-1:0]                in_fraction;
  logic [DW-1:0]               in_dirs;
  logic [CW-1:0]               in_accel;
  logic [CW-1:0]               in_travel;
  logic [CW-1:0]               in_decel;
  logic [W-1:0]                in_series;
  logic [W-1:0]                in_ramp;
  logic [W-1:0]                in_tdelay;

  assign in_op       = in_tuser[1:0];
  assign in_exit     = in_tuser[2];
  assign in_motor    = in_tdata[sdrg_pkg::IN_MOTOR_LO  +: sdrg_pkg::MIDX_W];
  assign in_fraction = in_tdata[sdrg_pkg::IN_FRAC_LO   +: W];
  assign in_dirs     = in_tdata[sdrg_pkg::IN_DIR_LO    +: DW];
  assign in_accel    = in_tdata[sdrg_pkg::IN_ACCEL_LO  +: CW];
  assign in_travel   = in_tdata[sdrg_pkg::IN_TRAVEL_LO +: CW];
  assign in_decel    = in_tdata[sdrg_pkg::IN_DECEL_LO  +: CW];
  assign in_series   = in_tdata[sdrg_pkg::IN_SERIES_LO +: W];
  assign in_ramp     = in_tdata[sdrg_pkg::IN_RAMP_LO   +: W];
  assign in_tdelay   = in_tdata[sdrg_pkg::IN_TDLY_LO   +: W];

  // segment state
  state_t                   state_r, state_nxt;
  logic [DW-1:0]            dirs_r, dirs_nxt;
  logic [CW-1:0]            accel_r, accel_nxt;
  logic [CW-1:0]            travel_r, travel_nxt;
  logic [CW-1:0]            decel_r, decel_nxt;
  logic [W-1:0]             series_r, series_nxt;
  logic [W-1:0]             ramp_r, ramp_nxt;
  logic [W-1:0]             divrem_r, divrem_nxt;
  logic [W-1:0]             tcyc_r, tcyc_nxt;
  logic                     active_r, active_nxt;

  // pending result
  logic [DW-1:0]            pend_pulses_r, pend_pulses_nxt;
  sdrg_pkg::phase_t         pend_phase_r, pend_phase_nxt;
  logic                     pend_done_r, pend_done_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [DW-1:0]            out_pulses_r, out_pulses_nxt;
  logic [DW-1:0]            out_dirs_r, out_dirs_nxt;
  logic [W-1:0]             out_delay_r, out_delay_nxt;
  sdrg_pkg::phase_t         out_phase_r, out_phase_nxt;
  logic                     out_done_r, out_done_nxt;

  logic                     in_fire;
  sdrg_pkg::acc_ctl_t       acc_ctl;
  logic [DW-1:0]            acc_pulses;
  logic                     div_start;
  logic [W-1:0]             div_dividend;
  logic [W-1:0]             div_divisor;
  logic                     div_done;
  logic [W-1:0]             div_quo;
  logic [W-1:0]             div_rem;
  logic [W-1:0]             emit_delay;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // accumulator bank control from the accepted word
  always_comb begin
    acc_ctl.load    = in_fire && (in_op == sdrg_pkg::OP_LOAD);
    acc_ctl.motor   = in_motor;
    acc_ctl.value   = in_fraction;
    acc_ctl.clear   = in_fire && (in_op == sdrg_pkg::OP_START) && !in_exit;
    acc_ctl.advance = in_fire && (in_op == sdrg_pkg::OP_ADVANCE) && active_r;
  end

  sdrg_accum #(
    .MOTORS (MOTORS)
  ) u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (acc_ctl),
    .pulses (acc_pulses)
  );

  // ramp divide operands: (2c + r) over 4n + 1 or 4n - 1
  assign div_dividend = {ramp_r[W-2:0], 1'b0} + divrem_r;
  assign div_divisor  = (accel_r != '0) ? {series_r[W-3:0], 2'b01}
                                        : {series_r[W-3:0], 2'b00} - W'(1);

  sdrg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // delay reported for the pending phase
  always_comb begin
    case (pend_phase_r) inside
      sdrg_pkg::PH_ACCEL, sdrg_pkg::PH_DECEL: emit_delay = ramp_r >> DELAY_FRACTION_BITS;
      sdrg_pkg::PH_TRAVEL:                    emit_delay = tcyc_r;
      default:                                emit_delay = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    dirs_nxt        = dirs_r;
    accel_nxt       = accel_r;
    travel_nxt      = travel_r;
    decel_nxt       = decel_r;
    series_nxt      = series_r;
    ramp_nxt        = ramp_r;
    divrem_nxt      = divrem_r;
    tcyc_nxt        = tcyc_r;
    active_nxt      = active_r;
    pend_pulses_nxt = pend_pulses_r;
    pend_phase_nxt  = pend_phase_r;
    pend_done_nxt   = pend_done_r;
    out_valid_nxt   = out_valid_r;
    out_pulses_nxt  = out_pulses_r;
    out_dirs_nxt    = out_dirs_r;
    out_delay_nxt   = out_delay_r;
    out_phase_nxt   = out_phase_r;
    out_done_nxt    = out_done_r;
    div_start       = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            sdrg_pkg::OP_START: begin
              if (!in_exit) begin
                dirs_nxt   = in_dirs;
                accel_nxt  = in_accel;
                travel_nxt = in_travel;
                decel_nxt  = in_decel;
                series_nxt = in_series;
                ramp_nxt   = in_ramp;
                tcyc_nxt   = in_tdelay;
                divrem_nxt = '0;
                active_nxt = 1'b1;
              end
            end
            sdrg_pkg::OP_ADVANCE: begin
              state_nxt = ST_EMIT;
              if (!active_r) begin
                pend_pulses_nxt = '0;
                pend_phase_nxt  = sdrg_pkg::PH_DONE;
                pend_done_nxt   = 1'b1;
              end else begin
                pend_pulses_nxt = acc_pulses;
                pend_done_nxt   = 1'b0;
                if (accel_r != '0) begin
                  accel_nxt      = accel_r - 1'b1;
                  series_nxt     = series_r + 1'b1;
                  pend_phase_nxt = sdrg_pkg::PH_ACCEL;
                  if (series_r != '0) begin
                    div_start = 1'b1;
                    state_nxt = ST_DIV;
                  end
                end else if (travel_r != '0) begin
                  travel_nxt     = travel_r - 1'b1;
                  pend_phase_nxt = sdrg_pkg::PH_TRAVEL;
                end else if (decel_r != '0) begin
                  decel_nxt      = decel_r - 1'b1;
                  series_nxt     = series_r - 1'b1;
                  pend_phase_nxt = sdrg_pkg::PH_DECEL;
                  div_start      = 1'b1;
                  state_nxt      = ST_DIV;
                end else begin
                  active_nxt     = 1'b0;
                  pend_done_nxt  = 1'b1;
                  pend_phase_nxt = sdrg_pkg::PH_DONE;
                end
              end
            end
            default: begin
              // fraction loads live in the accumulator bank
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ramp_nxt   = (pend_phase_r == sdrg_pkg::PH_ACCEL) ? ramp_r - div_quo
                                                            : ramp_r + div_quo;
          divrem_nxt = div_rem;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_pulses_nxt = pend_pulses_r;
          out_dirs_nxt   = dirs_r;
          out_delay_nxt  = emit_delay;
          out_phase_nxt  = pend_phase_r;
          out_done_nxt   = pend_done_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pend_pulses_r <= pend_pulses_nxt;
    pend_phase_r  <= pend_phase_nxt;
    pend_done_r   <= pend_done_nxt;
    out_pulses_r  <= out_pulses_nxt;
    out_dirs_r    <= out_dirs_nxt;
    out_delay_r   <= out_delay_nxt;
    out_phase_r   <= out_phase_nxt;
    out_done_r    <= out_done_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dirs_r      <= '0;
      accel_r     <= '0;
      travel_r    <= '0;
      decel_r     <= '0;
      series_r    <= '0;
      ramp_r      <= '0;
      divrem_r    <= '0;
      tcyc_r      <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dirs_r      <= dirs_nxt;
      accel_r     <= accel_nxt;
      travel_r    <= travel_nxt;
      decel_r     <= decel_nxt;
      series_r    <= series_nxt;
      ramp_r      <= ramp_nxt;
      divrem_r    <= divrem_nxt;
      tcyc_r      <= tcyc_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_delay_r, out_dirs_r, out_pulses_r};
  assign out_tuser  = {out_done_r, out_phase_r};

endmodule
`default_nettype wire

>>> sv/sdrg_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module sdrg_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [sdrg_pkg::WORD_W-1:0] dividend,
  input  wire logic [sdrg_pkg::WORD_W-1:0] divisor,
  output logic                           done,
  output logic [sdrg_pkg::WORD_W-1:0]    quotient,
  output logic [sdrg_pkg::WORD_W-1:0]    remainder
);

  localparam int unsigned W   = sdrg_pkg::WORD_W;
  localparam int unsigned CNT_W = $clog2(W);

  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       ge;

  // trial subtract of the shifted partial remainder
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[W-2:0], ge};
      rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

>>> sv/sdrg_accum.sv
`default_nettype none
// per-motor fractions and phase accumulators
module sdrg_accum #(
  parameter int unsigned MOTORS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sdrg_pkg::acc_ctl_t           ctl,
  output logic [sdrg_pkg::MAX_MOTORS-1:0]   pulses
);

  localparam int unsigned W = sdrg_pkg::WORD_W;

  logic [W-1:0] frac_r [MOTORS];
  logic [W-1:0] acc_r  [MOTORS];
  logic [W-1:0] sum    [MOTORS];

  for (genvar i = 0; i < MOTORS; i++) begin : g_motor
    // top bit rising 0 to 1 makes a step
    assign sum[i]    = acc_r[i] + frac_r[i];
    assign pulses[i] = ~acc_r[i][W-1] & sum[i][W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        frac_r[i] <= '0;
        acc_r[i]  <= '0;
      end else begin
        if (ctl.load && ctl.motor == sdrg_pkg::MIDX_W'(i)) begin
          frac_r[i] <= ctl.value;
        end
        if (ctl.clear) begin
          acc_r[i] <= '0;
        end else if (ctl.advance) begin
          acc_r[i] <= sum[i];
        end
      end
    end
  end

  // motors not built never step
  if (MOTORS < sdrg_pkg::MAX_MOTORS) begin : g_unused
    assign pulses[sdrg_pkg::MAX_MOTORS-1:MOTORS] = '0;
  end

endmodule
`default_nettype wire
